FILE: src/bfa_pkg.sv
// Shared types, constants and codes for the bitmap frame allocator.
package bfa_pkg;

	localparam int DEF_BITMAP_WORDS = 32;
	localparam int BLOCK_BYTES      = 4096;
	localparam int BLK_SHIFT        = $clog2(BLOCK_BYTES);
	localparam int BITS_PER_WORD    = 32;
	localparam int WIU_W            = 6;
	localparam int CNT_W            = 11;
	localparam int ADDR_W           = 32;
	localparam int PADDR_W          = 3;
	localparam int REG_SEL_BIT      = 2;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_STATS = 2'd2;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NO_SPACE = 2'd1;
	localparam logic [1:0] STS_RANGE    = 2'd2;

	localparam logic REG_USER_BASE    = 1'b0;
	localparam logic REG_WORDS_IN_USE = 1'b1;

	localparam logic [WIU_W-1:0] WIU_RESET = 6'd32;

	typedef struct packed {
		logic        has_zero;
		logic [4:0]  zero_pos;
		logic [31:0] zero_bit;
		logic [5:0]  ones;
	} scan_res_t;

endpackage

FILE: src/bfa_bitmap_mem.sv
// Bitmap word store: one write port, one registered read port, per-word valid bits.
module bfa_bitmap_mem #(
	parameter int DEPTH = 32,
	parameter int IDX_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [31:0]      rd_word,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [31:0]      wr_word
);
	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [31:0]      data_q;
	logic             vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_idx] <= 1'b1;
			if (rd_en)
				vld_q <= valid_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_word;
		if (rd_en)
			data_q <= mem[rd_idx];
	end

	// never-written words read as free
	assign rd_word = vld_q ? data_q : 32'd0;

endmodule

FILE: src/bfa_word_unit.sv
// Shared word unit: first clear bit and population count of one bitmap word.
module bfa_word_unit (
	input  logic [31:0]        word,
	output bfa_pkg::scan_res_t res
);
	import bfa_pkg::*;

	logic [31:0] inv;
	logic [31:0] low;
	logic [4:0]  pos;
	logic [1:0]  l1 [16];
	logic [2:0]  l2 [8];
	logic [3:0]  l3 [4];
	logic [4:0]  l4 [2];

	assign inv = ~word;
	assign low = inv & (~inv + 32'd1);

	always_comb begin
		pos = 5'd0;
		for (int j = 0; j < 32; j++) begin
			if (low[j])
				pos = pos | 5'(j);
		end
	end

	always_comb begin
		for (int a = 0; a < 16; a++)
			l1[a] = {1'b0, word[2*a]} + {1'b0, word[2*a+1]};
		for (int b = 0; b < 8; b++)
			l2[b] = {1'b0, l1[2*b]} + {1'b0, l1[2*b+1]};
		for (int c = 0; c < 4; c++)
			l3[c] = {1'b0, l2[2*c]} + {1'b0, l2[2*c+1]};
		for (int d = 0; d < 2; d++)
			l4[d] = {1'b0, l3[2*d]} + {1'b0, l3[2*d+1]};
	end

	assign res.has_zero = |inv;
	assign res.zero_pos = pos;
	assign res.zero_bit = low;
	assign res.ones     = {1'b0, l4[0]} + {1'b0, l4[1]};

endmodule

FILE: src/bitmap_frame_allocator_top.sv
// Bitmap frame allocator top level: sequencer, config registers and output register.
// Alloc: result valid after a scan of the words in use (one word a cycle
//   through the shared word unit), one address add and one output load.
// One item at a time: the next item is taken in the cycle after the result is loaded;
//   a full output stalls it.
// Reset (arst_n, async): bitmap reads all free, user_base 0, words_in_use 32.
module bitmap_frame_allocator_top #(
	parameter int BITMAP_WORDS = bfa_pkg::DEF_BITMAP_WORDS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// slave stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,  // [31:0] free_addr
	input  logic [1:0]                  s_tuser,  // [1:0] req_type
	// master stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [55:0]                 m_tdata,  // [31:0] alloc_address, [42:32] total_blocks,
	                                              // [53:43] used_blocks, [55:54] zero
	output logic [1:0]                  m_tuser,  // [1:0] status
	// config
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import bfa_pkg::*;

	localparam int MEM_WORDS = (BITMAP_WORDS < 63) ? BITMAP_WORDS : 63;
	localparam int IDX_W     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int BLK_W     = ADDR_W - BLK_SHIFT;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_ADDR = 3'd2;
	localparam logic [2:0] ST_FCHK = 3'd3;
	localparam logic [2:0] ST_FWR  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]        state_q;
	logic [1:0]        op_q;
	logic [ADDR_W-1:0] base_q;
	logic [WIU_W-1:0]  wiu_q;
	logic [WIU_W-1:0]  n_words;
	logic [WIU_W-1:0]  idx_q;
	logic [ADDR_W-1:0] off_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [1:0]        res_sts_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  k_q;
	logic [IDX_W-1:0]  fidx_q;
	logic [4:0]        fbit_q;
	logic              m_tvalid_q;
	logic [55:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_idx;
	logic [31:0]       rd_word;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [31:0]       wr_word;
	scan_res_t         scan;

	logic              in_acc;
	logic              cfg_wr;
	logic              last_word;
	logic [BLK_W-1:0]  blk;
	logic              out_of_range;
	logic [CNT_W-1:0]  total;

	assign n_words      = (wiu_q > WIU_W'(MEM_WORDS)) ? WIU_W'(MEM_WORDS) : wiu_q;
	assign in_acc       = s_tvalid && s_tready;
	assign cfg_wr       = psel && penable && pwrite && pready;
	assign last_word    = (idx_q == (n_words - WIU_W'(1)));
	assign blk          = off_q[ADDR_W-1:BLK_SHIFT];
	assign out_of_range = (ADDR_W'(blk) >= ADDR_W'({n_words, 5'd0}));
	assign total        = (op_q == REQ_STATS) ? CNT_W'({n_words, 5'd0}) : '0;

	assign s_tready = (state_q == ST_IDLE);
	assign pready   = 1'b1;
	assign prdata   = paddr[REG_SEL_BIT] ? {{(32-WIU_W){1'b0}}, wiu_q} : base_q;

	bfa_bitmap_mem #(
		.DEPTH(MEM_WORDS),
		.IDX_W(IDX_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_idx (rd_idx),
		.rd_word(rd_word),
		.wr_en  (wr_en),
		.wr_idx (wr_idx),
		.wr_word(wr_word)
	);

	bfa_word_unit u_word (
		.word(rd_word),
		.res (scan)
	);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_idx  = '0;
		wr_en   = 1'b0;
		wr_idx  = idx_q[IDX_W-1:0];
		wr_word = rd_word | scan.zero_bit;
		unique case (state_q)
			ST_IDLE: begin
				rd_en  = in_acc;
				rd_idx = '0;
			end
			ST_SCAN: begin
				if (op_q == REQ_ALLOC && scan.has_zero) begin
					wr_en = 1'b1;
				end else if (!last_word) begin
					rd_en  = 1'b1;
					rd_idx = IDX_W'(idx_q + WIU_W'(1));
				end
			end
			ST_FCHK: begin
				rd_en  = !out_of_range;
				rd_idx = blk[5 +: IDX_W];
			end
			ST_FWR: begin
				wr_en   = 1'b1;
				wr_idx  = fidx_q;
				wr_word = rd_word & ~(32'd1 << fbit_q);
			end
			default: begin
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			wiu_q  <= WIU_RESET;
		end else if (cfg_wr) begin
			if (paddr[REG_SEL_BIT] == REG_USER_BASE)
				base_q <= pwdata;
			else
				wiu_q <= pwdata[WIU_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= REQ_ALLOC;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q <= s_tuser;
						if ((s_tuser == REQ_ALLOC || s_tuser == REQ_STATS) && n_words != '0)
							state_q <= ST_SCAN;
						else if (s_tuser == REQ_FREE)
							state_q <= ST_FCHK;
						else
							state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (op_q == REQ_ALLOC && scan.has_zero)
						state_q <= ST_ADDR;
					else if (last_word)
						state_q <= ST_DONE;
				end
				ST_ADDR: state_q <= ST_DONE;
				ST_FCHK: state_q <= out_of_range ? ST_DONE : ST_FWR;
				ST_FWR:  state_q <= ST_DONE;
				ST_DONE: begin
					if (!m_tvalid_q || m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					idx_q      <= '0;
					used_q     <= '0;
					res_addr_q <= '0;
					off_q      <= s_tdata - base_q;
					res_sts_q  <= (s_tuser == REQ_ALLOC && n_words == '0) ? STS_NO_SPACE
					                                                     : STS_OK;
				end
			end
			ST_SCAN: begin
				used_q <= used_q + CNT_W'(scan.ones);
				if (op_q == REQ_ALLOC && scan.has_zero)
					k_q <= {idx_q, scan.zero_pos};
				else if (last_word && op_q == REQ_ALLOC)
					res_sts_q <= STS_NO_SPACE;
				else
					idx_q <= idx_q + WIU_W'(1);
			end
			ST_ADDR: res_addr_q <= base_q + (ADDR_W'(k_q) << BLK_SHIFT);
			ST_FCHK: begin
				fidx_q <= blk[5 +: IDX_W];
				fbit_q <= blk[4:0];
				if (out_of_range)
					res_sts_q <= STS_RANGE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {2'b00,
					              (op_q == REQ_STATS) ? used_q : CNT_W'(0),
					              total, res_addr_q};
					m_tuser_q <= res_sts_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: src/bfa_checker.sv
// Port-level checker for the bitmap frame allocator, bound to the top level.
module bfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import bfa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again straight after an item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STS_OK || m_tuser == STS_NO_SPACE || m_tuser == STS_RANGE))
		else $error("unused status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STS_OK |-> m_tdata == 56'd0)
		else $error("failed request carries non-zero fields");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
